/* rtl/ekpi_pkg.sv */
// ----------------------------------------------------------------------------
// ekpi_pkg
// Shared types, constants and character helpers for the extended key path
// inserter.
// ----------------------------------------------------------------------------
package ekpi_pkg;

   localparam int TAIL_DEPTH = 9;
   localparam int IDX_W      = $clog2(TAIL_DEPTH);
   localparam int FILL_W     = $clog2(TAIL_DEPTH + 1);
   localparam int SUFFIX_LEN = 8;
   localparam int SIDX_W     = $clog2(SUFFIX_LEN);

   localparam logic [7:0] CHR_HASH  = 8'h23;  // '#'
   localparam logic [7:0] CHR_SLASH = 8'h2f;  // '/'
   localparam logic [7:0] CHR_X     = 8'h78;  // 'x'
   localparam logic [7:0] CHR_T     = 8'h74;  // 't'
   localparam logic [7:0] CHR_P     = 8'h70;  // 'p'
   localparam logic [7:0] CHR_U     = 8'h75;  // 'u'
   localparam logic [7:0] CHR_B     = 8'h62;  // 'b'

   typedef enum logic [2:0] {
      M_IDLE,
      M_X,
      M_P,
      M_U,
      M_KEY
   } match_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_SUFFIX,
      ST_CHAR,
      ST_NEXT,
      ST_END_SUFFIX,
      ST_TAIL,
      ST_MARKER
   } ctrl_state_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_CUR,
      EM_SUFFIX,
      EM_TAIL,
      EM_MARKER
   } emit_type;

   typedef struct packed {
      logic              accept;     // take the request beat
      logic              load_next;  // move oldest held char into the current slot
      logic              upd_match;  // advance the matcher on the current char
      emit_type          emit;
      logic [SIDX_W-1:0] sidx;
      logic              last_beat;  // mark the result as end of text
      logic              clear;      // text finished, back to reset values
   } dp_cmd_type;

   typedef struct packed {
      logic fill_full;
      logic fill_zero;
      logic fill_one;
      logic need_suffix;
      logic key_after;
      logic match_key;
      logic checksum;
      logic inserted;
      logic out_free;
   } dp_status_type;

   function automatic logic is_base58(input logic [7:0] c);
      logic r;
      r = c inside {[8'h31:8'h39], [8'h41:8'h48], [8'h4a:8'h4e], [8'h50:8'h5a],
                    [8'h61:8'h6b], [8'h6d:8'h7a]};
      return r;
   endfunction

   function automatic match_type next_match(input match_type m, input logic [7:0] c);
      match_type r;
      if (m == M_KEY) begin
         r = is_base58(c) ? M_KEY : M_IDLE;
      end else if (m == M_X && c == CHR_P) begin
         r = M_P;
      end else if (m == M_P && c == CHR_U) begin
         r = M_U;
      end else if (m == M_U && c == CHR_B) begin
         r = M_KEY;
      end else if (c == CHR_X || c == CHR_T) begin
         r = M_X;
      end else begin
         r = M_IDLE;
      end
      return r;
   endfunction

   // "/<0;1>/*"
   function automatic logic [7:0] suffix_char(input logic [SIDX_W-1:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h2f;
         3'd1:    r = 8'h3c;
         3'd2:    r = 8'h30;
         3'd3:    r = 8'h3b;
         3'd4:    r = 8'h31;
         3'd5:    r = 8'h3e;
         3'd6:    r = 8'h2f;
         3'd7:    r = 8'h2a;
         default: r = 8'h2a;
      endcase
      return r;
   endfunction

endpackage

/* rtl/ekpi_datapath.sv */
// ----------------------------------------------------------------------------
// ekpi_datapath
// Tail delay line, key matcher, flags and the result register.
// ----------------------------------------------------------------------------
module ekpi_datapath
   import ekpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type st,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast,
   output logic [1:0]    rsp_tuser
);

   logic [7:0]        dl_ff [TAIL_DEPTH];
   logic [7:0]        dl_in [TAIL_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        cur_ff, cur_in;
   match_type         match_ff, match_in;
   logic              ins_ff, ins_in;
   logic              spilled_ff, spilled_in;
   logic              chk_ff, chk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_end_ff, rsp_end_in;
   logic              rsp_mod_ff, rsp_mod_in;
   logic              fill_full;
   match_type         match_nxt;

   assign fill_full = (fill_ff == FILL_W'(TAIL_DEPTH - 1));
   assign match_nxt = next_match(match_ff, cur_ff);

   always_comb begin
      st.fill_full   = fill_full;
      st.fill_zero   = (fill_ff == '0);
      st.fill_one    = (fill_ff == FILL_W'(1));
      st.need_suffix = (match_ff == M_KEY) && !is_base58(cur_ff) && (cur_ff != CHR_SLASH);
      st.key_after   = (match_nxt == M_KEY);
      st.match_key   = (match_ff == M_KEY);
      st.checksum    = chk_ff;
      st.inserted    = ins_ff;
      st.out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      dl_in        = dl_ff;
      fill_in      = fill_ff;
      cur_in       = cur_ff;
      match_in     = match_ff;
      ins_in       = ins_ff;
      spilled_in   = spilled_ff;
      chk_in       = chk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_mod_in   = rsp_mod_ff;

      if (cmd.accept) begin
         dl_in[fill_ff[IDX_W-1:0]] = req_tdata;
         if (!req_tlast) begin
            if (fill_full) begin
               // oldest char leaves, the rest slide down
               cur_in = dl_ff[0];
               for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
                  dl_in[i] = dl_ff[i+1];
               end
               dl_in[TAIL_DEPTH-2] = req_tdata;
               spilled_in = 1'b1;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end else begin
            fill_in = fill_ff + FILL_W'(1);
            chk_in  = spilled_ff && fill_full && (dl_ff[0] == CHR_HASH);
         end
      end

      if (cmd.load_next || cmd.emit == EM_TAIL) begin
         cur_in = dl_ff[0];
         for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
            dl_in[i] = dl_ff[i+1];
         end
         fill_in = fill_ff - FILL_W'(1);
      end

      if (cmd.upd_match) begin
         match_in = match_nxt;
      end

      if (cmd.emit == EM_SUFFIX) begin
         ins_in = 1'b1;
      end

      if (cmd.emit != EM_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_has_in   = (cmd.emit != EM_MARKER);
         rsp_end_in   = cmd.last_beat;
         rsp_mod_in   = ins_ff || (cmd.emit == EM_SUFFIX);
         case (cmd.emit)
            EM_CUR:    rsp_char_in = cur_ff;
            EM_SUFFIX: rsp_char_in = suffix_char(cmd.sidx);
            EM_TAIL:   rsp_char_in = dl_ff[0];
            default:   rsp_char_in = 8'h00;
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.clear) begin
         fill_in    = '0;
         match_in   = M_IDLE;
         ins_in     = 1'b0;
         spilled_in = 1'b0;
         chk_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         match_ff     <= M_IDLE;
         ins_ff       <= 1'b0;
         spilled_ff   <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         match_ff     <= match_in;
         ins_ff       <= ins_in;
         spilled_ff   <= spilled_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff       <= dl_in;
      cur_ff      <= cur_in;
      rsp_char_ff <= rsp_char_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_mod_ff  <= rsp_mod_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tuser  = {rsp_mod_ff, rsp_has_ff};

endmodule

/* rtl/ekpi_ctrl.sv */
// ----------------------------------------------------------------------------
// ekpi_ctrl
// Sequencer: takes request beats and orders the result beats of each char,
// suffix, end-of-text flush, checksum tail and end-only marker.
// ----------------------------------------------------------------------------
module ekpi_ctrl
   import ekpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tlast,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);

   ctrl_state_type    state_ff, state_in;
   logic              flush_ff, flush_in;
   logic [SIDX_W-1:0] sidx_ff, sidx_in;
   logic              cur_end;
   logic              sidx_last;

   // last content char of the text and no key run left open after it
   assign cur_end   = flush_ff && st.fill_zero && !st.key_after;
   assign sidx_last = (sidx_ff == SIDX_W'(SUFFIX_LEN - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tlast) begin
                  state_in = ST_NEXT;
               end else if (st.fill_full) begin
                  state_in = ST_FEED;
               end
            end
         end
         ST_FEED: begin
            if (st.need_suffix) begin
               state_in = ST_SUFFIX;
            end else if (st.out_free) begin
               state_in = (flush_ff && !cur_end) ? ST_NEXT : ST_IDLE;
            end
         end
         ST_SUFFIX: begin
            if (st.out_free && sidx_last) begin
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (st.out_free) begin
               state_in = (flush_ff && !cur_end) ? ST_NEXT : ST_IDLE;
            end
         end
         ST_NEXT: begin
            if (!st.checksum && !st.fill_zero) begin
               state_in = ST_FEED;
            end else if (st.match_key) begin
               state_in = ST_END_SUFFIX;
            end else if (st.checksum && !st.inserted) begin
               state_in = ST_TAIL;
            end else begin
               state_in = ST_MARKER;
            end
         end
         ST_END_SUFFIX: begin
            if (st.out_free && sidx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (st.out_free && st.fill_one) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARKER: begin
            if (st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready    = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_next = 1'b0;
      cmd.upd_match = 1'b0;
      cmd.emit      = EM_NONE;
      cmd.sidx      = sidx_ff;
      cmd.last_beat = 1'b0;
      cmd.clear     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_FEED, ST_CHAR: begin
            if ((state_ff == ST_CHAR || !st.need_suffix) && st.out_free) begin
               cmd.emit      = EM_CUR;
               cmd.upd_match = 1'b1;
               cmd.last_beat = cur_end;
               cmd.clear     = cur_end;
            end
         end
         ST_SUFFIX: begin
            if (st.out_free) begin
               cmd.emit = EM_SUFFIX;
            end
         end
         ST_NEXT: begin
            cmd.load_next = !st.checksum && !st.fill_zero;
         end
         ST_END_SUFFIX: begin
            if (st.out_free) begin
               cmd.emit      = EM_SUFFIX;
               cmd.last_beat = sidx_last;
               cmd.clear     = sidx_last;
            end
         end
         ST_TAIL: begin
            if (st.out_free) begin
               cmd.emit      = EM_TAIL;
               cmd.last_beat = st.fill_one;
               cmd.clear     = st.fill_one;
            end
         end
         ST_MARKER: begin
            if (st.out_free) begin
               cmd.emit      = EM_MARKER;
               cmd.last_beat = 1'b1;
               cmd.clear     = 1'b1;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      flush_in = flush_ff;
      sidx_in  = sidx_ff;
      if (cmd.accept && req_tlast) begin
         flush_in = 1'b1;
      end
      if (cmd.clear) begin
         flush_in = 1'b0;
      end
      if (cmd.emit == EM_SUFFIX) begin
         sidx_in = sidx_ff + SIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flush_ff <= 1'b0;
         sidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
         sidx_ff  <= sidx_in;
      end
   end

endmodule

/* rtl/extended_key_path_inserter.sv */
// ----------------------------------------------------------------------------
// extended_key_path_inserter
// Appends "/<0;1>/*" to extended keys without a derivation path in a
// streamed descriptor text; drops a trailing checksum when the text changed.
// ----------------------------------------------------------------------------
// Characters enter one beat per cycle until eight are held in the nine-deep
// tail buffer. After that each further character is taken in ST_IDLE, which
// moves the oldest held char into the current slot, and ST_FEED loads that
// char into the result register. When a path suffix goes in ahead of it,
// ST_FEED spots the end of the key run, ST_SUFFIX emits the eight suffix
// beats, then ST_CHAR emits the char. The controller takes no input while it
// emits. On the last beat the held chars are flushed, each content char via
// ST_NEXT and ST_FEED; a suffix there adds ST_SUFFIX and ST_CHAR, a closing
// one ST_END_SUFFIX, and a passed checksum ST_TAIL. The sequencer stalls
// while the result register is full and rsp_tready is low. No new text is
// taken until the final result of the current one has been loaded.
// ----------------------------------------------------------------------------
module extended_key_path_inserter
   import ekpi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [0] has_char, [1] modified
);

   dp_cmd_type    cmd;
   dp_status_type st;

   ekpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .st         (st),
      .cmd        (cmd)
   );

   ekpi_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // an end-only marker is always the final beat of a text and carries no char
   a_marker_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == 8'h00))
      else $error("end-only marker without tlast or with data");

   // the flush of a text blocks new input in the cycle after the last beat
   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input taken right after last beat");

   // a suffix beat always reports the text as modified
   a_suffix_modified: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit == EM_SUFFIX) |=> (rsp_tvalid && rsp_tuser[1]))
      else $error("suffix beat without modified flag");

   // the fill count is never both empty and full when input is taken
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(st.fill_zero && st.fill_full))
      else $error("tail buffer count inconsistent");

endmodule
